[rtl/core/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/sacsim_pkg.sv]
// constants and register codes for the cache simulator unit
package sacsim_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned TAG_W      = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned OUT_DATA_W = 104;
  localparam int unsigned RAW_SET_W  = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_TIME     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_PENALTY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VICTIM_POL   = 3'd5;

  // replacement policies
  localparam logic POLICY_LFU = 1'b0;
  localparam logic POLICY_LRU = 1'b1;

  typedef struct packed {
    logic [2:0]  index_bits;
    logic [4:0]  offset_bits;
    logic [3:0]  ways_in_use;
    logic [15:0] hit_time;
    logic [15:0] miss_penalty;
    logic        victim_policy;
  } cfg_regs_t;

endpackage

[rtl/core/set_assoc_cache_lru_lfu_sim_unit.sv]
// set-associative cache simulator with lfu / lru replacement
// the address is registered into stage 1 with its set row, and the result is
//   registered into m_tdata when stage 1 moves on; a held result stalls stage 1
// throughput: one address per cycle while not stalled; a row is written back as
//   stage 1 moves on, with a bypass for back-to-back accesses to one set
// reset: counters, stream valids and row-written flags clear, config to defaults
`include "assert_macros.svh"

module set_assoc_cache_lru_lfu_sim_unit
  import sacsim_pkg::*;
#(
  parameter int unsigned MAX_SETS   = 64,
  parameter int unsigned MAX_WAYS   = 8,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // address stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [ADDR_W-1:0]     s_tdata,   // [31:0] address
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [0] hit, [32:1] cycle_total, [64:33] reference_total, [96:65] miss_total
  output logic [OUT_DATA_W-1:0] m_tdata,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned RAW_SETS = 1 << RAW_SET_W;
  localparam int unsigned ROWS     = (MAX_SETS < RAW_SETS) ? MAX_SETS : RAW_SETS;
  localparam int unsigned SET_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned NW2      = 1 << $clog2(MAX_WAYS);
  localparam int unsigned IDX_W    = (NW2 > 1) ? $clog2(NW2) : 1;
  localparam int unsigned NODES    = 2 * NW2 - 1;
  localparam int unsigned AW_EFF   = (ADDR_WIDTH < ADDR_W) ? ADDR_WIDTH : ADDR_W;
  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (AW_EFF >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << AW_EFF) - 64'd1);

  // configuration
  cfg_regs_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.index_bits    <= 3'd0;
      cfg.offset_bits   <= 5'd0;
      cfg.ways_in_use   <= 4'd1;
      cfg.hit_time      <= 16'd1;
      cfg.miss_penalty  <= 16'd0;
      cfg.victim_policy <= POLICY_LRU;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INDEX_BITS:   cfg.index_bits    <= cfg_data[2:0];
        REG_OFFSET_BITS:  cfg.offset_bits   <= cfg_data[4:0];
        REG_WAYS_IN_USE:  cfg.ways_in_use   <= cfg_data[3:0];
        REG_HIT_TIME:     cfg.hit_time      <= cfg_data;
        REG_MISS_PENALTY: cfg.miss_penalty  <= cfg_data;
        REG_VICTIM_POL:   cfg.victim_policy <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // set index wrap table: raw index modulo the number of sets
  logic [SET_W-1:0] set_lut [RAW_SETS];

  for (genvar g = 0; g < RAW_SETS; g++) begin : g_set_lut
    assign set_lut[g] = SET_W'(g % MAX_SETS);
  end

  // address split on the input side
  logic [ADDR_W-1:0]    addr_m;
  logic [5:0]           shift;
  logic [TAG_W-1:0]     tag_in;
  logic [RAW_SET_W-1:0] raw_set;
  logic [SET_W-1:0]     set_in;

  always_comb begin
    addr_m  = s_tdata & ADDR_MASK;
    shift   = 6'(cfg.index_bits) + 6'(cfg.offset_bits);
    tag_in  = TAG_W'(addr_m >> shift);
    raw_set = RAW_SET_W'(addr_m >> cfg.offset_bits)
              & ((RAW_SET_W'(1) << cfg.index_bits) - RAW_SET_W'(1));
    set_in  = set_lut[raw_set];
  end

  // handshake
  logic s1_valid;
  logic s1_go;
  logic accept;
  logic wr_en;

  assign s1_go    = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || s1_go;
  assign accept   = s_tvalid && s_tready;
  assign wr_en    = s1_valid && s1_go;

  // row memory, one row per set holding all ways
  logic [MAX_WAYS-1:0]            valid_mem [ROWS];
  logic [MAX_WAYS-1:0][TAG_W-1:0] tag_mem   [ROWS];
  logic [MAX_WAYS-1:0][CNT_W-1:0] count_mem [ROWS];
  logic [MAX_WAYS-1:0][CNT_W-1:0] stamp_mem [ROWS];
  logic [ROWS-1:0]                row_written;

  logic [MAX_WAYS-1:0]            rd_valid;
  logic [MAX_WAYS-1:0][TAG_W-1:0] rd_tag;
  logic [MAX_WAYS-1:0][CNT_W-1:0] rd_count;
  logic [MAX_WAYS-1:0][CNT_W-1:0] rd_stamp;

  // last row written, for the bypass
  logic [MAX_WAYS-1:0]            last_valid;
  logic [MAX_WAYS-1:0][TAG_W-1:0] last_tag;
  logic [MAX_WAYS-1:0][CNT_W-1:0] last_count;
  logic [MAX_WAYS-1:0][CNT_W-1:0] last_stamp;
  logic [SET_W-1:0]               last_set;

  // stage 1 item
  logic [TAG_W-1:0] s1_tag;
  logic [SET_W-1:0] s1_set;
  logic             s1_row_ok;
  logic             s1_fwd;

  // updated row
  logic [MAX_WAYS-1:0]            new_valid;
  logic [MAX_WAYS-1:0][TAG_W-1:0] new_tag;
  logic [MAX_WAYS-1:0][CNT_W-1:0] new_count;
  logic [MAX_WAYS-1:0][CNT_W-1:0] new_stamp;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_valid <= valid_mem[set_in];
      rd_tag   <= tag_mem[set_in];
      rd_count <= count_mem[set_in];
      rd_stamp <= stamp_mem[set_in];
    end
    if (wr_en) begin
      valid_mem[s1_set] <= new_valid;
      tag_mem[s1_set]   <= new_tag;
      count_mem[s1_set] <= new_count;
      stamp_mem[s1_set] <= new_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_written <= '0;
    end else if (wr_en) begin
      row_written[s1_set] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_valid <= new_valid;
      last_tag   <= new_tag;
      last_count <= new_count;
      last_stamp <= new_stamp;
      last_set   <= s1_set;
    end
    if (accept) begin
      s1_tag    <= tag_in;
      s1_set    <= set_in;
      s1_row_ok <= row_written[set_in];
      // the row being written on this edge is not yet visible to the read
      s1_fwd    <= wr_en && (s1_set == set_in);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // current row seen by stage 1
  logic [MAX_WAYS-1:0]            cur_valid;
  logic [MAX_WAYS-1:0][TAG_W-1:0] cur_tag;
  logic [MAX_WAYS-1:0][CNT_W-1:0] cur_count;
  logic [MAX_WAYS-1:0][CNT_W-1:0] cur_stamp;

  always_comb begin
    if (s1_fwd) begin
      cur_valid = last_valid;
      cur_tag   = last_tag;
      cur_count = last_count;
      cur_stamp = last_stamp;
    end else if (s1_row_ok) begin
      cur_valid = rd_valid;
      cur_tag   = rd_tag;
      cur_count = rd_count;
      cur_stamp = rd_stamp;
    end else begin
      cur_valid = '0;
      cur_tag   = '0;
      cur_count = '0;
      cur_stamp = '0;
    end
  end

  // way search
  logic [MAX_WAYS-1:0] way_en;
  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] inv_vec;
  logic [MAX_WAYS-1:0] hit_1h;
  logic [MAX_WAYS-1:0] inv_1h;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      // ways_in_use of zero still uses way 0
      way_en[w]  = (w == 0) || (5'(w) < {1'b0, cfg.ways_in_use});
      hit_vec[w] = way_en[w] && cur_valid[w] && (cur_tag[w] == s1_tag);
      inv_vec[w] = way_en[w] && !cur_valid[w];
    end
    // lowest set bit
    hit_1h = hit_vec & (~hit_vec + MAX_WAYS'(1));
    inv_1h = inv_vec & (~inv_vec + MAX_WAYS'(1));
  end

  // victim: min tree over ways in use, left side wins ties
  logic [CNT_W-1:0] node_key [NODES];
  logic [IDX_W-1:0] node_idx [NODES];
  logic             node_en  [NODES];

  for (genvar l = 0; l < NW2; l++) begin : g_leaf
    if (l < MAX_WAYS) begin : g_used
      assign node_key[NW2-1+l] = (cfg.victim_policy == POLICY_LFU) ? cur_count[l]
                                                                   : cur_stamp[l];
      assign node_en[NW2-1+l]  = way_en[l];
    end else begin : g_pad
      assign node_key[NW2-1+l] = '0;
      assign node_en[NW2-1+l]  = 1'b0;
    end
    assign node_idx[NW2-1+l] = IDX_W'(l);
  end

  for (genvar n = 0; n < NW2 - 1; n++) begin : g_node
    logic take_left;
    assign take_left = node_en[2*n+1]
                       && (!node_en[2*n+2] || (node_key[2*n+1] <= node_key[2*n+2]));
    assign node_key[n] = take_left ? node_key[2*n+1] : node_key[2*n+2];
    assign node_idx[n] = take_left ? node_idx[2*n+1] : node_idx[2*n+2];
    assign node_en[n]  = node_en[2*n+1] || node_en[2*n+2];
  end

  logic [MAX_WAYS-1:0] vic_1h;
  logic [MAX_WAYS-1:0] sel_1h;
  logic                hit;

  // counters
  logic [CNT_W-1:0] cycle_counter;
  logic [CNT_W-1:0] reference_counter;
  logic [CNT_W-1:0] miss_counter;
  logic [CNT_W-1:0] cycle_counter_next;
  logic [CNT_W-1:0] reference_counter_next;
  logic [CNT_W-1:0] miss_counter_next;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      vic_1h[w] = (node_idx[0] == IDX_W'(w));
    end
    hit = |hit_vec;
    if (hit) begin
      sel_1h = hit_1h;
    end else if (|inv_vec) begin
      sel_1h = inv_1h;
    end else begin
      sel_1h = vic_1h;
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (sel_1h[w]) begin
        new_valid[w] = 1'b1;
        new_tag[w]   = s1_tag;
        new_count[w] = cur_count[w] + CNT_W'(1);
        new_stamp[w] = cycle_counter;
      end else begin
        new_valid[w] = cur_valid[w];
        new_tag[w]   = cur_tag[w];
        new_count[w] = cur_count[w];
        new_stamp[w] = cur_stamp[w];
      end
    end
    cycle_counter_next     = cycle_counter + CNT_W'(cfg.hit_time)
                             + (hit ? CNT_W'(0) : CNT_W'(cfg.miss_penalty));
    reference_counter_next = reference_counter + CNT_W'(1);
    miss_counter_next      = miss_counter + (hit ? CNT_W'(0) : CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_counter     <= '0;
      reference_counter <= '0;
      miss_counter      <= '0;
    end else if (wr_en) begin
      cycle_counter     <= cycle_counter_next;
      reference_counter <= reference_counter_next;
      miss_counter      <= miss_counter_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (wr_en) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      m_tdata <= {7'd0, miss_counter_next, reference_counter_next,
                  cycle_counter_next, hit};
    end
  end

  `ASSERT_SAME(a_one_way_updated, clk, rst, s1_valid, $onehot(sel_1h),
    "exactly one way must be chosen for update")
  `ASSERT_SAME(a_bypass_same_set, clk, rst, s1_valid && s1_fwd, s1_set == last_set,
    "bypass used for a different set")
  `ASSERT_NEXT(a_hit_keeps_misses, clk, rst, wr_en && hit,
    miss_counter == $past(miss_counter), "miss count moved on a hit")
  `ASSERT_SAME(a_stall_only_when_full, clk, rst, !s_tready,
    s1_valid && m_tvalid && !m_tready, "input stalled without a blocked result")

endmodule
